@@ sv/vcd_pkg.sv @@
`timescale 1ns / 1ps
package vcd_pkg;

	localparam int COORD_W    = 18;
	localparam int INT_W      = 16;
	localparam int INV_W      = 17;
	localparam int KEY_W      = 3 * COORD_W;
	localparam int PCNT_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = INV_W;

	localparam logic [CFG_IDX_W-1:0] CFG_INV_LEAF = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS   = 1'd1;
	localparam logic [INV_W-1:0]     INV_RESET    = 17'd819;

	localparam logic [63:0] HASH_GOLD = 64'h0000_0000_9e37_79b9;
	localparam int          HASH_SHL  = 6;
	localparam int          HASH_SHR  = 2;

	typedef enum logic [2:0] {
		KIND_ABSORBED = 3'd0,
		KIND_DROPPED  = 3'd1,
		KIND_PASSED   = 3'd2,
		KIND_CENTROID = 3'd3,
		KIND_EMPTY    = 3'd4
	} kind_t;

	function automatic logic [63:0] hash_mix(input logic [63:0] seed, input logic [63:0] v);
		return seed ^ (v + HASH_GOLD + (seed << HASH_SHL) + (seed >> HASH_SHR));
	endfunction

	function automatic logic [63:0] key_sext(input logic [COORD_W-1:0] k);
		return {{(64 - COORD_W){k[COORD_W-1]}}, k};
	endfunction

endpackage

@@ sv/vcd_if.sv @@
`timescale 1ns / 1ps
interface vcd_pt_if;
	logic                                valid;
	logic                                ready;
	logic                                action;
	logic signed [vcd_pkg::COORD_W-1:0] point_x;
	logic signed [vcd_pkg::COORD_W-1:0] point_y;
	logic signed [vcd_pkg::COORD_W-1:0] point_z;
	logic [vcd_pkg::INT_W-1:0]          point_intensity;
	logic                                point_finite;
	modport source(output valid, action, point_x, point_y, point_z, point_intensity,
		point_finite, input ready);
	modport sink(input valid, action, point_x, point_y, point_z, point_intensity,
		point_finite, output ready);
endinterface

interface vcd_res_if;
	logic                                valid;
	logic                                ready;
	vcd_pkg::kind_t                      kind;
	logic signed [vcd_pkg::COORD_W-1:0] out_x;
	logic signed [vcd_pkg::COORD_W-1:0] out_y;
	logic signed [vcd_pkg::COORD_W-1:0] out_z;
	logic [vcd_pkg::INT_W-1:0]          out_intensity;
	logic [vcd_pkg::PCNT_W-1:0]         point_count;
	logic                                last_voxel;
	logic                                overflow_seen;
	modport source(output valid, kind, out_x, out_y, out_z, out_intensity, point_count,
		last_voxel, overflow_seen, input ready);
	modport sink(input valid, kind, out_x, out_y, out_z, out_intensity, point_count,
		last_voxel, overflow_seen, output ready);
endinterface

interface vcd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [vcd_pkg::CFG_IDX_W-1:0]   index;
	logic [vcd_pkg::CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ sv/vcd_table.sv @@
`timescale 1ns / 1ps
module vcd_table #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

@@ sv/vcd_div.sv @@
`timescale 1ns / 1ps
module vcd_div #(
	parameter int NUM_W = 35,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_nx;
	logic             ge;

	assign rem_sh = {rem_q, acc_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	assign busy   = busy_q;
	assign quo    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_W-2:0], ge};
			rem_q <= rem_nx[DEN_W-1:0];
		end
	end
endmodule

@@ sv/voxel_centroid_downsample.sv @@
`timescale 1ns / 1ps
// input beat to result: bypass, dropped and drain-empty beats go from ST_IDLE straight to ST_EMIT
// table add: ST_MUL, ST_KEY, ST_HASH, ST_PROBE (up to MAX_PROBE slots from the home slot, ending
// early on a match), ST_UPDATE, ST_EMIT; drain: ST_SCAN from the drain pointer to the next used slot,
// then ST_DIVS, ST_DIVW, ST_EMIT; one item in flight: a new beat is taken only in ST_IDLE, and a
// stalled result holds the output register; the slot table is a single-port-read synchronous memory
// reset: asynchronous, then a clearing pass over all TABLE_DEPTH slots before the first beat is taken
module voxel_centroid_downsample #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_PROBE   = 16,
	parameter int COUNT_BITS  = 16
) (
	input logic      clk,
	input logic      arst_n,
	vcd_pt_if.sink   pts,
	vcd_res_if.source res,
	vcd_cfg_if.sink  cfg
);
	import vcd_pkg::*;

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int OW    = AW + 1;
	localparam int SUM_W = COORD_W + COUNT_BITS + 1;
	localparam int IW    = INT_W + COUNT_BITS;
	localparam int LIMIT = (MAX_PROBE < TABLE_DEPTH) ? MAX_PROBE : TABLE_DEPTH;
	localparam int PW    = $clog2(LIMIT + 1);
	localparam int CWX   = (COUNT_BITS > PCNT_W) ? COUNT_BITS : PCNT_W;
	localparam int PRW   = COORD_W + INV_W + 1;

	typedef struct packed {
		logic                    valid;
		logic [KEY_W-1:0]        key;
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] sz;
		logic [IW-1:0]           si;
		logic [COUNT_BITS-1:0]   cnt;
	} entry_t;

	localparam int EW = $bits(entry_t);
	localparam logic [COUNT_BITS-1:0] MAX_CNT = '1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_MUL, ST_KEY, ST_HASH, ST_PROBE,
		ST_UPDATE, ST_SCAN, ST_DIVS, ST_DIVW, ST_EMIT
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [PW-1:0]       iss_q;
	logic                rd_v_s1;
	logic [AW-1:0]       rd_a_s1;
	logic                match_q;
	logic                empty_q;
	logic                ovf_q;
	logic [OW-1:0]       occ_q;
	logic [AW-1:0]       drain_q;
	logic [INV_W-1:0]    inv_q;
	logic                byp_q;
	logic                o_v_q;

	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic [INT_W-1:0]          pi_q;
	logic signed [PRW-1:0]     prx_s1, pry_s1, prz_s1;
	logic [KEY_W-1:0]          key_q;
	logic [63:0]               h1_q;
	logic [AW-1:0]             home_q;
	logic [AW-1:0]             found_q;
	logic [AW-1:0]             empty_a_q;
	logic [AW-1:0]             sc_q;
	entry_t                    ent_q;

	kind_t                     r_kind_q, o_kind_q;
	logic signed [COORD_W-1:0] r_x_q, r_y_q, r_z_q, o_x_q, o_y_q, o_z_q;
	logic [INT_W-1:0]          r_i_q, o_i_q;
	logic [PCNT_W-1:0]         r_cnt_q, o_cnt_q;
	logic                      r_last_q, o_last_q, o_ovf_q;

	logic          acc;
	logic          out_free;
	logic          issue;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_raw;
	entry_t        rd_ent;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_ent;
	entry_t        upd_ent;
	entry_t        new_ent;
	logic          hit_probe;
	logic          hit_scan;
	logic [63:0]   h2;

	logic [SUM_W-1:0] nx, ny, nz, qx, qy, qz, half;
	logic [IW-1:0]    ni, qi;
	logic             bx, by, bz, bi, busy_any;
	logic [CWX-1:0]   cnt_ext;

	assign pts.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign acc       = pts.valid && pts.ready;
	assign out_free  = !o_v_q || res.ready;

	assign res.valid         = o_v_q;
	assign res.kind          = o_kind_q;
	assign res.out_x         = o_x_q;
	assign res.out_y         = o_y_q;
	assign res.out_z         = o_z_q;
	assign res.out_intensity = o_i_q;
	assign res.point_count   = o_cnt_q;
	assign res.last_voxel    = o_last_q;
	assign res.overflow_seen = o_ovf_q;

	assign rd_ent    = entry_t'(rd_raw);
	assign hit_probe = rd_v_s1 && rd_ent.valid && (rd_ent.key == key_q);
	assign hit_scan  = rd_v_s1 && rd_ent.valid;
	assign issue     = ((state_q == ST_PROBE) && (iss_q < PW'(LIMIT))) || (state_q == ST_SCAN);
	assign rd_addr   = (state_q == ST_PROBE) ? home_q + AW'(iss_q) : sc_q;
	assign h2        = hash_mix(h1_q, key_sext(key_q[COORD_W-1:0]));

	always_comb begin
		upd_ent = ent_q;
		if (ent_q.cnt != MAX_CNT) begin
			upd_ent.sx  = ent_q.sx + SUM_W'(px_q);
			upd_ent.sy  = ent_q.sy + SUM_W'(py_q);
			upd_ent.sz  = ent_q.sz + SUM_W'(pz_q);
			upd_ent.si  = ent_q.si + IW'(pi_q);
			upd_ent.cnt = ent_q.cnt + 1'b1;
		end
		new_ent.valid = 1'b1;
		new_ent.key   = key_q;
		new_ent.sx    = SUM_W'(px_q);
		new_ent.sy    = SUM_W'(py_q);
		new_ent.sz    = SUM_W'(pz_q);
		new_ent.si    = IW'(pi_q);
		new_ent.cnt   = COUNT_BITS'(1);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = found_q;
		wr_ent  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ST_UPDATE: begin
				if (match_q) begin
					wr_en  = 1'b1;
					wr_ent = upd_ent;
				end else if (empty_q) begin
					wr_en   = 1'b1;
					wr_addr = empty_a_q;
					wr_ent  = new_ent;
				end
			end
			ST_DIVS: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	vcd_table #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_tab (
		.clk     (clk),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_raw),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (EW'(wr_ent))
	);

	assign half = SUM_W'(ent_q.cnt >> 1);
	assign nx   = (ent_q.sx[SUM_W-1] ? SUM_W'(-ent_q.sx) : SUM_W'(ent_q.sx)) + half;
	assign ny   = (ent_q.sy[SUM_W-1] ? SUM_W'(-ent_q.sy) : SUM_W'(ent_q.sy)) + half;
	assign nz   = (ent_q.sz[SUM_W-1] ? SUM_W'(-ent_q.sz) : SUM_W'(ent_q.sz)) + half;
	assign ni   = ent_q.si + IW'(ent_q.cnt >> 1);
	assign busy_any = bx || by || bz || bi;
	assign cnt_ext  = CWX'(ent_q.cnt);

	vcd_div #(.NUM_W(SUM_W), .DEN_W(COUNT_BITS)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIVS), .num(nx), .den(ent_q.cnt),
		.busy(bx), .quo(qx));
	vcd_div #(.NUM_W(SUM_W), .DEN_W(COUNT_BITS)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIVS), .num(ny), .den(ent_q.cnt),
		.busy(by), .quo(qy));
	vcd_div #(.NUM_W(SUM_W), .DEN_W(COUNT_BITS)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIVS), .num(nz), .den(ent_q.cnt),
		.busy(bz), .quo(qz));
	vcd_div #(.NUM_W(IW), .DEN_W(COUNT_BITS)) u_div_i (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIVS), .num(ni), .den(ent_q.cnt),
		.busy(bi), .quo(qi));

	// control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			iss_q   <= '0;
			rd_v_s1 <= 1'b0;
			match_q <= 1'b0;
			empty_q <= 1'b0;
			ovf_q   <= 1'b0;
			occ_q   <= '0;
			drain_q <= '0;
			inv_q   <= INV_RESET;
			byp_q   <= 1'b0;
			o_v_q   <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_INV_LEAF: inv_q <= cfg.data;
					CFG_BYPASS:   byp_q <= cfg.data[0];
					default:      inv_q <= inv_q;
				endcase
			end
			if (res.ready && !(state_q == ST_EMIT && out_free)) begin
				o_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (pts.action) begin
							state_q <= (occ_q == '0) ? ST_EMIT : ST_SCAN;
						end else if (byp_q || !pts.point_finite) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL:  state_q <= ST_KEY;
				ST_KEY:  state_q <= ST_HASH;
				ST_HASH: begin
					iss_q   <= '0;
					match_q <= 1'b0;
					empty_q <= 1'b0;
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (hit_probe) begin
						match_q <= 1'b1;
						state_q <= ST_UPDATE;
					end else begin
						if (rd_v_s1 && !rd_ent.valid) begin
							empty_q <= 1'b1;
						end
						if (iss_q == PW'(LIMIT) && !rd_v_s1) begin
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					if (!match_q && empty_q) begin
						occ_q <= occ_q + 1'b1;
					end else if (!match_q) begin
						ovf_q <= 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_SCAN: begin
					if (hit_scan) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					occ_q   <= occ_q - 1'b1;
					drain_q <= found_q + 1'b1;
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (!busy_any) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						o_v_q   <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		rd_a_s1 <= rd_addr;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					px_q     <= pts.point_x;
					py_q     <= pts.point_y;
					pz_q     <= pts.point_z;
					pi_q     <= pts.point_intensity;
					sc_q     <= drain_q;
					r_x_q    <= '0;
					r_y_q    <= '0;
					r_z_q    <= '0;
					r_i_q    <= '0;
					r_cnt_q  <= '0;
					r_last_q <= 1'b0;
					if (pts.action) begin
						r_kind_q <= KIND_EMPTY;
					end else if (byp_q) begin
						r_kind_q <= KIND_PASSED;
						r_x_q    <= pts.point_x;
						r_y_q    <= pts.point_y;
						r_z_q    <= pts.point_z;
						r_i_q    <= pts.point_intensity;
						r_cnt_q  <= PCNT_W'(1);
					end else if (!pts.point_finite) begin
						r_kind_q <= KIND_DROPPED;
					end else begin
						r_kind_q <= KIND_ABSORBED;
					end
				end
			end
			ST_MUL: begin
				prx_s1 <= PRW'($signed(px_q) * $signed({1'b0, inv_q}));
				pry_s1 <= PRW'($signed(py_q) * $signed({1'b0, inv_q}));
				prz_s1 <= PRW'($signed(pz_q) * $signed({1'b0, inv_q}));
			end
			ST_KEY: begin
				key_q <= {prx_s1[COORD_W+15:16], pry_s1[COORD_W+15:16], prz_s1[COORD_W+15:16]};
				h1_q  <= hash_mix(key_sext(prx_s1[COORD_W+15:16]),
					key_sext(pry_s1[COORD_W+15:16]));
			end
			ST_HASH: begin
				home_q <= h2[AW-1:0];
			end
			ST_PROBE: begin
				if (hit_probe) begin
					found_q <= rd_a_s1;
					ent_q   <= rd_ent;
				end else if (rd_v_s1 && !rd_ent.valid && !empty_q) begin
					empty_a_q <= rd_a_s1;
				end
			end
			ST_UPDATE: begin
				r_kind_q <= (match_q || empty_q) ? KIND_ABSORBED : KIND_DROPPED;
			end
			ST_SCAN: begin
				sc_q <= sc_q + 1'b1;
				if (hit_scan) begin
					found_q <= rd_a_s1;
					ent_q   <= rd_ent;
				end
			end
			ST_DIVW: begin
				r_kind_q <= KIND_CENTROID;
				r_x_q    <= ent_q.sx[SUM_W-1] ? -qx[COORD_W-1:0] : qx[COORD_W-1:0];
				r_y_q    <= ent_q.sy[SUM_W-1] ? -qy[COORD_W-1:0] : qy[COORD_W-1:0];
				r_z_q    <= ent_q.sz[SUM_W-1] ? -qz[COORD_W-1:0] : qz[COORD_W-1:0];
				r_i_q    <= qi[INT_W-1:0];
				r_cnt_q  <= (cnt_ext > CWX'(65535)) ? '1 : cnt_ext[PCNT_W-1:0];
				r_last_q <= (occ_q == '0);
			end
			ST_EMIT: begin
				if (out_free) begin
					o_kind_q <= r_kind_q;
					o_x_q    <= r_x_q;
					o_y_q    <= r_y_q;
					o_z_q    <= r_z_q;
					o_i_q    <= r_i_q;
					o_cnt_q  <= r_cnt_q;
					o_last_q <= r_last_q;
					o_ovf_q  <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

@@ sv/vcd_chk.sv @@
`timescale 1ns / 1ps
module vcd_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input vcd_pkg::kind_t               kind,
	input logic [vcd_pkg::COORD_W-1:0] out_x,
	input logic [vcd_pkg::PCNT_W-1:0]  point_count,
	input logic                         last_voxel,
	input logic                         overflow_seen
);
	import vcd_pkg::*;

	logic beat;
	assign beat = res_valid && res_ready;

	a_sticky_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		beat && overflow_seen |=> !(res_valid && !overflow_seen))
		else $error("overflow flag fell");

	a_pass_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_PASSED |-> point_count == 16'd1)
		else $error("passed beat count not one");

	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_ABSORBED || kind == KIND_DROPPED || kind == KIND_EMPTY)
		|-> out_x == '0 && point_count == '0 && !last_voxel)
		else $error("payload on quiet beat");

	a_centroid_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_CENTROID |-> point_count != '0)
		else $error("centroid with zero count");
endmodule

bind voxel_centroid_downsample vcd_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.kind          (res.kind),
	.out_x         (res.out_x),
	.point_count   (res.point_count),
	.last_voxel    (res.last_voxel),
	.overflow_seen (res.overflow_seen)
);

@@ test/voxel_centroid_checker.sv @@
`timescale 1ns / 1ps
module voxel_centroid_checker #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_PROBE   = 16,
	parameter int COUNT_BITS  = 16
) (
	input logic  clk,
	input logic  arst_n,
	vcd_pt_if    pts,
	vcd_res_if   res,
	vcd_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import vcd_pkg::*;

	typedef struct packed {
		kind_t                     kind;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [INT_W-1:0]          inten;
		logic [PCNT_W-1:0]         cnt;
		logic                      last;
		logic                      ovf;
	} voxel_result_t;

	voxel_result_t result_q[$];

	logic [KEY_W-1:0]    vkey[TABLE_DEPTH];
	logic                vused[TABLE_DEPTH];
	longint              vsx[TABLE_DEPTH];
	longint              vsy[TABLE_DEPTH];
	longint              vsz[TABLE_DEPTH];
	longint              vsi[TABLE_DEPTH];
	int                  vcnt[TABLE_DEPTH];
	int                  drain_ptr;
	logic                ovf_flag;
	logic [INV_W-1:0]    inv_leaf;
	logic                bypass;

	function automatic logic [COORD_W-1:0] floor_key(longint c);
		longint p;
		p = c * longint'(inv_leaf);
		return COORD_W'(p >>> 16);
	endfunction

	function automatic logic [63:0] sx64(logic [COORD_W-1:0] k);
		return {{(64 - COORD_W){k[COORD_W-1]}}, k};
	endfunction

	function automatic logic [63:0] combine(logic [63:0] s, logic [63:0] v);
		return s ^ (v + 64'h9e3779b9 + (s << 6) + (s >> 2));
	endfunction

	function automatic longint rdiv(longint s, longint c);
		if (s >= 0)
			return (s + c / 2) / c;
		return -((-s + c / 2) / c);
	endfunction

	function automatic voxel_result_t predict_voxel(logic act, logic signed [COORD_W-1:0] px,
		logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz, logic [INT_W-1:0] pi,
		logic fin);
		voxel_result_t r;
		logic [COORD_W-1:0] kx, ky, kz;
		logic [KEY_W-1:0] key;
		logic [63:0] h;
		int home, s, found, empty, c;
		bit have_match, have_empty, hit, more;
		r = '0;
		have_match = 0;
		have_empty = 0;
		found = 0;
		empty = 0;
		if (!act) begin
			if (bypass) begin
				r.kind = KIND_PASSED;
				r.x = px;
				r.y = py;
				r.z = pz;
				r.inten = pi;
				r.cnt = PCNT_W'(1);
			end else if (!fin) begin
				r.kind = KIND_DROPPED;
			end else begin
				kx = floor_key(px);
				ky = floor_key(py);
				kz = floor_key(pz);
				key = {kx, ky, kz};
				h = combine(combine(sx64(kx), sx64(ky)), sx64(kz));
				home = int'(h % TABLE_DEPTH);
				for (int i = 0; i < MAX_PROBE && i < TABLE_DEPTH; i++) begin
					s = (home + i) % TABLE_DEPTH;
					if (vused[s]) begin
						if (!have_match && vkey[s] == key) begin
							have_match = 1;
							found = s;
						end
					end else if (!have_empty) begin
						have_empty = 1;
						empty = s;
					end
				end
				if (!have_match && have_empty) begin
					found = empty;
					vused[found] = 1;
					vkey[found] = key;
					vsx[found] = 0;
					vsy[found] = 0;
					vsz[found] = 0;
					vsi[found] = 0;
					vcnt[found] = 0;
					have_match = 1;
				end
				if (have_match) begin
					if (vcnt[found] < (1 << COUNT_BITS) - 1) begin
						vsx[found] += px;
						vsy[found] += py;
						vsz[found] += pz;
						vsi[found] += pi;
						vcnt[found]++;
					end
					r.kind = KIND_ABSORBED;
				end else begin
					ovf_flag = 1;
					r.kind = KIND_DROPPED;
				end
			end
		end else begin
			hit = 0;
			s = 0;
			for (int i = 0; i < TABLE_DEPTH && !hit; i++) begin
				s = (drain_ptr + i) % TABLE_DEPTH;
				if (vused[s])
					hit = 1;
			end
			if (!hit) begin
				r.kind = KIND_EMPTY;
			end else begin
				c = vcnt[s] < 1 ? 1 : vcnt[s];
				r.kind = KIND_CENTROID;
				r.x = COORD_W'(rdiv(vsx[s], c));
				r.y = COORD_W'(rdiv(vsy[s], c));
				r.z = COORD_W'(rdiv(vsz[s], c));
				r.inten = INT_W'((vsi[s] + c / 2) / c);
				r.cnt = vcnt[s] > 65535 ? 16'hffff : PCNT_W'(vcnt[s]);
				vused[s] = 0;
				more = 0;
				for (int j = 0; j < TABLE_DEPTH; j++)
					if (vused[j])
						more = 1;
				r.last = !more;
				drain_ptr = (s + 1) % TABLE_DEPTH;
			end
		end
		r.ovf = ovf_flag;
		return r;
	endfunction

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		voxel_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				vused[i] = 0;
			drain_ptr = 0;
			ovf_flag = 0;
			inv_leaf = INV_RESET;
			bypass = 0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_INV_LEAF)
					inv_leaf = cfg.data;
				else if (cfg.index == CFG_BYPASS)
					bypass = cfg.data[0];
			end
			if (pts.valid && pts.ready)
				result_q.insert(result_q.size(), predict_voxel(pts.action, pts.point_x,
					pts.point_y, pts.point_z, pts.point_intensity, pts.point_finite));
			if (res.valid && res.ready) begin
				if (result_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat kind %0d", $time, res.kind);
				end else begin
					e = result_q.pop_front();
					if (res.kind !== e.kind || res.out_x !== e.x || res.out_y !== e.y ||
						res.out_z !== e.z || res.out_intensity !== e.inten ||
						res.point_count !== e.cnt || res.last_voxel !== e.last ||
						res.overflow_seen !== e.ovf) begin
						fail_count++;
						$display("%0t: expected k%0d x%0d y%0d z%0d i%0d n%0d l%0b o%0b", $time,
							e.kind, e.x, e.y, e.z, e.inten, e.cnt, e.last, e.ovf);
						$display("%0t: actual   k%0d x%0d y%0d z%0d i%0d n%0d l%0b o%0b", $time,
							res.kind, res.out_x, res.out_y, res.out_z, res.out_intensity,
							res.point_count, res.last_voxel, res.overflow_seen);
					end
				end
			end
		end
	end

endmodule

@@ test/voxel_centroid_downsample_tb.sv @@
`timescale 1ns / 1ps
module voxel_centroid_downsample_tb;
	import vcd_pkg::*;

	localparam int TABLE_GUARD = 40;
	localparam int HOLD_LEN    = 300;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   hold_off = 0;
	bit   hold_req;
	bit   hold_seen = 1'b0;
	bit   stalls_on;

	vcd_pt_if  pts();
	vcd_res_if res();
	vcd_cfg_if cfg();

	voxel_centroid_downsample u_dut (.clk(clk), .arst_n(arst_n), .pts(pts), .res(res),
		.cfg(cfg));

	voxel_centroid_checker u_chk (.clk(clk), .arst_n(arst_n), .pts(pts), .res(res),
		.cfg(cfg), .fail_count(fail_count), .pending(pending));

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 20000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stall pattern plus one long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_off <= HOLD_LEN;
			res.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			res.ready <= 1'b0;
		end else if (stalls_on) begin
			res.ready <= ($urandom_range(0, 7) > 2);
		end else begin
			res.ready <= 1'b1;
		end
	end

	task automatic send_beat(logic act, int x, int y, int z, int inten, logic fin);
		pts.valid <= 1'b1;
		pts.action <= act;
		pts.point_x <= COORD_W'(x);
		pts.point_y <= COORD_W'(y);
		pts.point_z <= COORD_W'(z);
		pts.point_intensity <= INT_W'(inten);
		pts.point_finite <= fin;
		do
			@(posedge clk);
		while (!pts.ready);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		pts.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		pts.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (TABLE_GUARD) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= CFG_DATA_W'(val);
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(int n, int spread);
		int burst;
		int k;
		int cx, cy, cz;
		k = 0;
		while (k < n) begin
			burst = $urandom_range(1, 12);
			cx = $urandom_range(0, 2 * spread) - spread;
			cy = $urandom_range(0, 2 * spread) - spread;
			cz = $urandom_range(0, 2 * spread) - spread;
			for (int b = 0; b < burst && k < n; b++) begin
				if ($urandom_range(0, 9) == 0)
					send_beat(1'b1, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
				else if ($urandom_range(0, 9) == 0)
					send_beat(1'b0, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
				else
					send_beat(1'b0, cx + $urandom_range(0, 40) - 20, cy + $urandom_range(0, 40)
						- 20, cz + $urandom_range(0, 40) - 20, $urandom, 1'b1);
				k++;
			end
			if ($urandom_range(0, 2) != 0)
				idle_gap($urandom_range(0, 8));
		end
		pts.valid <= 1'b0;
	endtask

	task automatic drain_all();
		for (int i = 0; i < 40; i++)
			send_beat(1'b1, 0, 0, 0, 0, 1'b0);
		pts.valid <= 1'b0;
	endtask

	initial begin
		hold_req = 1'b0;
		stalls_on = 0;
		arst_n = 1'b0;
		pts.valid = 1'b0;
		pts.action = 1'b0;
		pts.point_x = '0;
		pts.point_y = '0;
		pts.point_z = '0;
		pts.point_intensity = '0;
		pts.point_finite = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, drain empty, duplicates, rounding, non-finite
		send_beat(1'b1, 0, 0, 0, 0, 1'b1);
		send_beat(1'b0, 131071, 131071, 131071, 65535, 1'b1);
		send_beat(1'b0, 131071, 131071, 131071, 65535, 1'b1);
		send_beat(1'b0, -131072, -131072, -131072, 0, 1'b1);
		send_beat(1'b0, -131071, -131072, -131071, 1, 1'b1);
		send_beat(1'b0, 5, -5, 0, 3, 1'b1);
		send_beat(1'b0, 6, -6, 1, 4, 1'b1);
		send_beat(1'b0, 12, 12, 12, 12, 1'b0);
		send_beat(1'b1, 0, 0, 0, 0, 1'b1);
		send_beat(1'b1, 0, 0, 0, 0, 1'b1);
		send_beat(1'b1, 0, 0, 0, 0, 1'b1);
		send_beat(1'b1, 0, 0, 0, 0, 1'b1);
		send_beat(1'b1, 0, 0, 0, 0, 1'b1);

		write_reg(CFG_BYPASS, 1);
		send_beat(1'b0, -131072, 131071, -1, 65535, 1'b0);
		send_beat(1'b0, 131071, -131072, 0, 0, 1'b1);
		send_beat(1'b1, 0, 0, 0, 0, 1'b1);
		stalls_on = 1;
		random_phase(60, 131000);
		write_reg(CFG_BYPASS, 0);

		// zero inverse folds everything into one voxel
		write_reg(CFG_INV_LEAF, 0);
		random_phase(40, 131000);
		drain_all();
		write_reg(CFG_INV_LEAF, 65536);
		for (int i = 0; i < 40; i++)
			send_beat(1'b0, i * 7, 3, 0, i, 1'b1);
		pts.valid <= 1'b0;
		hold_req = 1'b1;
		random_phase(40, 2000);
		drain_all();

		write_reg(CFG_INV_LEAF, 131071);
		random_phase(60, 131000);
		write_reg(CFG_INV_LEAF, 1);
		random_phase(60, 131000);
		write_reg(CFG_INV_LEAF, INV_RESET);
		stalls_on = 0;
		random_phase(60, 3000);
		stalls_on = 1;
		write_reg(CFG_INV_LEAF, $urandom_range(1, 65536));
		random_phase(80, 20000);
		drain_all();

		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
